@@ rtl/core/cslu_pkg.sv @@
`default_nettype none
package cslu_pkg;

  localparam int unsigned SIDE    = 16;
  localparam int unsigned COORD_W = $clog2(SIDE);
  localparam int unsigned ADDR_W  = 3 * COORD_W;
  localparam int unsigned SITES   = SIDE * SIDE * SIDE;
  localparam int unsigned COUNT_W = $clog2(SITES) + 1;
  localparam int unsigned OUT_W   = 13;
  localparam int unsigned RATE_W  = 17;
  localparam int unsigned DRAW_W  = 16;
  localparam int unsigned DIR_W   = 3;
  localparam int unsigned SP_W    = 2;
  localparam int unsigned NUM_SP  = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 56;

  localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(65536);

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;
  localparam logic EV_SWAP    = 1'b0;
  localparam logic EV_PRED    = 1'b1;

  localparam logic [DIR_W-1:0] DIR_PX = 3'd0;
  localparam logic [DIR_W-1:0] DIR_PY = 3'd1;
  localparam logic [DIR_W-1:0] DIR_NX = 3'd2;
  localparam logic [DIR_W-1:0] DIR_NY = 3'd3;
  localparam logic [DIR_W-1:0] DIR_PZ = 3'd4;
  localparam logic [DIR_W-1:0] DIR_NZ = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_SWAP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEATH_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEATH_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEATH_C = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEATH_D = 3'd4;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [SP_W-1:0]    sp_t;
  typedef logic [RATE_W-1:0]  rate_t;
  typedef logic [DRAW_W-1:0]  draw_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    logic changed;
    logic wr_ctr;
    sp_t  ctr_sp;
    logic wr_nbr;
    sp_t  nbr_sp;
    logic cnt_en;
    sp_t  inc_sp;
    sp_t  dec_sp;
  } act_t;

  typedef struct packed {
    logic en;
    sp_t  inc_sp;
    sp_t  dec_sp;
  } cnt_upd_t;

  function automatic coord_t coord_inc(input coord_t c);
    coord_t r;
    r = (c == coord_t'(SIDE - 1)) ? '0 : c + coord_t'(1);
    return r;
  endfunction

  function automatic coord_t coord_dec(input coord_t c);
    coord_t r;
    r = (c == '0) ? coord_t'(SIDE - 1) : c - coord_t'(1);
    return r;
  endfunction

  function automatic addr_t site_addr(input coord_t x, input coord_t y, input coord_t z);
    addr_t r;
    r = {x, y, z};
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/cslu_lattice_ram.sv @@
`default_nettype none
module cslu_lattice_ram (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire cslu_pkg::addr_t waddr_i,
  input  wire cslu_pkg::sp_t   wdata_i,
  input  wire logic            re_i,
  input  wire cslu_pkg::addr_t raddr_a_i,
  input  wire cslu_pkg::addr_t raddr_b_i,
  output cslu_pkg::sp_t        rdata_a_o,
  output cslu_pkg::sp_t        rdata_b_o
);
  import cslu_pkg::*;

  sp_t mem [SITES];
  sp_t rdata_a_q;
  sp_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule
`default_nettype wire

@@ rtl/core/cslu_rule.sv @@
`default_nettype none
module cslu_rule (
  input  wire logic             cmd_i,
  input  wire cslu_pkg::sp_t    load_sp_i,
  input  wire logic             dir_ok_i,
  input  wire logic             kind_i,
  input  wire cslu_pkg::draw_t  swap_draw_i,
  input  wire cslu_pkg::draw_t  death_draw_i,
  input  wire cslu_pkg::sp_t    me_i,
  input  wire cslu_pkg::sp_t    nb_i,
  input  wire cslu_pkg::rate_t  swap_rate_i,
  input  wire cslu_pkg::rate_t  death_rate_i [cslu_pkg::NUM_SP],
  input  wire cslu_pkg::count_t cnt_i [cslu_pkg::NUM_SP],
  output cslu_pkg::act_t        act_o
);
  import cslu_pkg::*;

  sp_t   prey;
  sp_t   pred;
  logic  interact;
  logic  swap_hit;
  logic  eat_hit;
  logic  eaten_hit;
  rate_t swap_draw_ext;
  rate_t death_draw_ext;

  assign prey           = me_i + sp_t'(1);
  assign pred           = me_i + sp_t'(3);
  assign swap_draw_ext  = {1'b0, swap_draw_i};
  assign death_draw_ext = {1'b0, death_draw_i};
  assign interact       = dir_ok_i && ((nb_i == prey) || (nb_i == pred));
  assign swap_hit       = (swap_draw_ext <= swap_rate_i);
  assign eat_hit        = (death_draw_ext <= death_rate_i[prey]) && (cnt_i[prey] != '0);
  assign eaten_hit      = (death_draw_ext <= death_rate_i[me_i]) && (cnt_i[me_i] != '0);

  always_comb begin
    act_o = '0;
    if (cmd_i == CMD_LOAD) begin
      if (me_i != load_sp_i) begin
        act_o.changed = 1'b1;
        act_o.wr_ctr  = 1'b1;
        act_o.ctr_sp  = load_sp_i;
        act_o.cnt_en  = 1'b1;
        act_o.inc_sp  = load_sp_i;
        act_o.dec_sp  = me_i;
      end
    end else if (interact) begin
      if (kind_i == EV_SWAP) begin
        if (swap_hit) begin
          act_o.changed = 1'b1;
          act_o.wr_ctr  = 1'b1;
          act_o.ctr_sp  = nb_i;
          act_o.wr_nbr  = 1'b1;
          act_o.nbr_sp  = me_i;
        end
      end else if (nb_i == prey) begin
        if (eat_hit) begin
          act_o.changed = 1'b1;
          act_o.wr_nbr  = 1'b1;
          act_o.nbr_sp  = me_i;
          act_o.cnt_en  = 1'b1;
          act_o.inc_sp  = me_i;
          act_o.dec_sp  = prey;
        end
      end else if (eaten_hit) begin
        act_o.changed = 1'b1;
        act_o.wr_ctr  = 1'b1;
        act_o.ctr_sp  = pred;
        act_o.cnt_en  = 1'b1;
        act_o.inc_sp  = pred;
        act_o.dec_sp  = me_i;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/cslu_counts.sv @@
`default_nettype none
module cslu_counts (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cslu_pkg::cnt_upd_t upd_i,
  output cslu_pkg::count_t        cnt_o [cslu_pkg::NUM_SP],
  output logic                    absorbed_o
);
  import cslu_pkg::*;

  count_t cnt_q [NUM_SP];
  logic [COUNT_W:0] sum_ac;
  logic [COUNT_W:0] sum_bd;
  logic [COUNT_W:0] total;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q[0] <= count_t'(SITES);
      cnt_q[1] <= '0;
      cnt_q[2] <= '0;
      cnt_q[3] <= '0;
    end else if (upd_i.en) begin
      cnt_q[upd_i.inc_sp] <= cnt_q[upd_i.inc_sp] + count_t'(1);
      cnt_q[upd_i.dec_sp] <= cnt_q[upd_i.dec_sp] - count_t'(1);
    end
  end

  assign total  = (COUNT_W + 1)'(SITES);
  assign sum_ac = {1'b0, cnt_q[0]} + {1'b0, cnt_q[2]};
  assign sum_bd = {1'b0, cnt_q[1]} + {1'b0, cnt_q[3]};

  assign absorbed_o = (cnt_q[0] == count_t'(SITES)) || (cnt_q[1] == count_t'(SITES)) ||
                      (cnt_q[2] == count_t'(SITES)) || (cnt_q[3] == count_t'(SITES)) ||
                      (sum_ac == total) || (sum_bd == total);

  assign cnt_o = cnt_q;

endmodule
`default_nettype wire

@@ rtl/core/cyclic_species_lattice_update.sv @@
// An accepted item is read from the lattice RAM and evaluated in ST_EVAL into a
// registered result for every kind of item; evaluation waits while an earlier
// result is still held. No new item is accepted until the last is evaluated, and
// a successful swap first writes its second site in ST_WR2 on the single RAM
// write port. A waiting result blocks evaluation of the next item, not acceptance.
// Reset: counts reload at once; a clearing pass writes species a into all 4096 sites,
// one per cycle, and holds off input transactions until the pass is done.
`default_nettype none
module cyclic_species_lattice_update (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // site_x, site_y, site_z, load_species, direction, event_kind, swap_draw, death_draw
  input  wire logic [cslu_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // cmd
  input  wire logic                               s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // changed, count_a, count_b, count_c, count_d, absorbed
  output logic [cslu_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [cslu_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [cslu_pkg::RATE_W-1:0]        cfg_data_i
);
  import cslu_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_WR2
  } state_e;

  state_e state_q;
  addr_t  clr_q;
  logic   out_valid_q;
  logic   changed_q;

  logic   cmd_q;
  addr_t  ctr_addr_q;
  addr_t  nbr_addr_q;
  logic   dir_ok_q;
  logic   kind_q;
  sp_t    load_sp_q;
  draw_t  swap_draw_q;
  draw_t  death_draw_q;
  sp_t    nbr_sp_q;

  rate_t  swap_rate_q;
  rate_t  death_rate_q [NUM_SP];

  coord_t in_x;
  coord_t in_y;
  coord_t in_z;
  logic [DIR_W-1:0] in_dir;
  coord_t nx;
  coord_t ny;
  coord_t nz;
  logic   in_dir_ok;
  logic   s_fire;
  logic   eval_go;

  logic   ram_we;
  addr_t  ram_waddr;
  sp_t    ram_wdata;
  sp_t    me;
  sp_t    nb;
  act_t   act;
  cnt_upd_t cnt_upd;
  count_t cnt [NUM_SP];
  logic   absorbed;

  assign in_x   = s_axis_tdata[3:0];
  assign in_y   = s_axis_tdata[7:4];
  assign in_z   = s_axis_tdata[11:8];
  assign in_dir = s_axis_tdata[16:14];

  always_comb begin
    nx = in_x;
    ny = in_y;
    nz = in_z;
    in_dir_ok = 1'b1;
    unique case (in_dir)
      DIR_PX:  nx = coord_inc(in_x);
      DIR_PY:  ny = coord_inc(in_y);
      DIR_NX:  nx = coord_dec(in_x);
      DIR_NY:  ny = coord_dec(in_y);
      DIR_PZ:  nz = coord_inc(in_z);
      DIR_NZ:  nz = coord_dec(in_z);
      default: in_dir_ok = 1'b0;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign eval_go       = (state_q == ST_EVAL) && (!out_valid_q || m_axis_tready);
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_rate_q     <= RATE_ONE;
      death_rate_q[0] <= RATE_ONE;
      death_rate_q[1] <= RATE_ONE;
      death_rate_q[2] <= RATE_ONE;
      death_rate_q[3] <= RATE_ONE;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SWAP:    swap_rate_q     <= cfg_data_i;
        REG_DEATH_A: death_rate_q[0] <= cfg_data_i;
        REG_DEATH_B: death_rate_q[1] <= cfg_data_i;
        REG_DEATH_C: death_rate_q[2] <= cfg_data_i;
        REG_DEATH_D: death_rate_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      cmd_q        <= s_axis_tuser;
      ctr_addr_q   <= site_addr(in_x, in_y, in_z);
      nbr_addr_q   <= site_addr(nx, ny, nz);
      dir_ok_q     <= in_dir_ok;
      load_sp_q    <= s_axis_tdata[13:12];
      kind_q       <= s_axis_tdata[17];
      swap_draw_q  <= s_axis_tdata[33:18];
      death_draw_q <= s_axis_tdata[49:34];
    end
    if (eval_go) begin
      nbr_sp_q <= act.nbr_sp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      changed_q   <= 1'b0;
    end else begin
      if (eval_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + addr_t'(1);
          if (clr_q == addr_t'(SITES - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_fire) begin
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (eval_go) begin
            changed_q   <= act.changed;
            state_q     <= (act.wr_ctr && act.wr_nbr) ? ST_WR2 : ST_IDLE;
          end
        end
        ST_WR2: begin
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_q;
    ram_wdata = '0;
    unique case (state_q)
      ST_CLEAR: ram_we = 1'b1;
      ST_EVAL: begin
        if (eval_go && act.wr_ctr) begin
          ram_we    = 1'b1;
          ram_waddr = ctr_addr_q;
          ram_wdata = act.ctr_sp;
        end else if (eval_go && act.wr_nbr) begin
          ram_we    = 1'b1;
          ram_waddr = nbr_addr_q;
          ram_wdata = act.nbr_sp;
        end
      end
      ST_WR2: begin
        ram_we    = 1'b1;
        ram_waddr = nbr_addr_q;
        ram_wdata = nbr_sp_q;
      end
      default: ;
    endcase
  end

  cslu_lattice_ram u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (s_fire),
    .raddr_a_i (site_addr(in_x, in_y, in_z)),
    .raddr_b_i (site_addr(nx, ny, nz)),
    .rdata_a_o (me),
    .rdata_b_o (nb)
  );

  cslu_rule u_rule (
    .cmd_i        (cmd_q),
    .load_sp_i    (load_sp_q),
    .dir_ok_i     (dir_ok_q),
    .kind_i       (kind_q),
    .swap_draw_i  (swap_draw_q),
    .death_draw_i (death_draw_q),
    .me_i         (me),
    .nb_i         (nb),
    .swap_rate_i  (swap_rate_q),
    .death_rate_i (death_rate_q),
    .cnt_i        (cnt),
    .act_o        (act)
  );

  assign cnt_upd.en     = eval_go && act.cnt_en;
  assign cnt_upd.inc_sp = act.inc_sp;
  assign cnt_upd.dec_sp = act.dec_sp;

  cslu_counts u_counts (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (cnt_upd),
    .cnt_o      (cnt),
    .absorbed_o (absorbed)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, absorbed, cnt[3][OUT_W-1:0], cnt[2][OUT_W-1:0],
                          cnt[1][OUT_W-1:0], cnt[0][OUT_W-1:0], changed_q};

  a_no_result_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !m_axis_tvalid)
    else $error("result shown during clearing pass");

  a_count_total : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((COUNT_W + 2)'(cnt[0]) + (COUNT_W + 2)'(cnt[1]) + (COUNT_W + 2)'(cnt[2]) +
     (COUNT_W + 2)'(cnt[3])) == (COUNT_W + 2)'(SITES))
    else $error("species counts do not sum to site total");

  a_swap_second_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (eval_go && act.wr_ctr && act.wr_nbr) |=> (state_q == ST_WR2) && !s_axis_tready)
    else $error("swap second write not held off from next read");

  a_eval_follows_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> (state_q == ST_EVAL))
    else $error("accepted item not evaluated");

endmodule
`default_nettype wire
